// File: rtl/core/wcs_pkg.sv
`default_nettype none
package wcs_pkg;

	localparam int unsigned SEC_W    = 12;
	localparam int unsigned DUTY_W   = 8;
	localparam int unsigned DEB_W    = 16;
	localparam int unsigned MS_W     = 24;
	localparam int unsigned PHASE_MS_W = 22;
	localparam int unsigned CFG_IDX_W  = 3;

	localparam logic [PHASE_MS_W-1:0] MS_PER_S = PHASE_MS_W'(1000);
	localparam logic [PHASE_MS_W-1:0] MAX22    = {PHASE_MS_W{1'b1}};
	localparam logic [MS_W-1:0]       MAX24    = {MS_W{1'b1}};

	// register file indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WASH_SECONDS   = 3'd0,
		CFG_RINSE_SECONDS  = 3'd1,
		CFG_SPIN_SECONDS   = 3'd2,
		CFG_MOTOR_SPEED    = 3'd3,
		CFG_DEBOUNCE_MS    = 3'd4,
		CFG_REST_MS        = 3'd5,
		CFG_RUN_LIMIT_MS   = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_WASH  = 2'd1,
		PH_RINSE = 2'd2,
		PH_SPIN  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		DIR_STOP = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_REV  = 2'd2
	} dir_t;

	typedef struct packed {
		logic [SEC_W-1:0]  wash_seconds;
		logic [SEC_W-1:0]  rinse_seconds;
		logic [SEC_W-1:0]  spin_seconds;
		logic [DUTY_W-1:0] motor_speed;
		logic [DEB_W-1:0]  debounce_ms;
		logic [MS_W-1:0]   rest_ms;
		logic [MS_W-1:0]   run_limit_ms;
	} cfg_t;

	typedef struct packed {
		dir_t              motor_dir;
		logic [DUTY_W-1:0] motor_duty;
		logic              pump_on;
		logic              lamp_on;
		phase_t            cycle_phase;
		logic              cycle_ended;
		logic              timed_out;
	} res_t;

endpackage
`default_nettype wire

// File: rtl/core/wcs_if.sv
`default_nettype none
// sensor tick channel
interface wcs_in_if;
	logic valid;
	logic ready;
	logic sensor_edge;

	modport source (output valid, output sensor_edge, input ready);
	modport sink (input valid, input sensor_edge, output ready);
endinterface

// actuator result channel
interface wcs_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] motor_dir;
	logic [7:0] motor_duty;
	logic       pump_on;
	logic       lamp_on;
	logic [1:0] cycle_phase;
	logic       cycle_ended;
	logic       timed_out;

	modport source (output valid, output motor_dir, output motor_duty, output pump_on,
		output lamp_on, output cycle_phase, output cycle_ended, output timed_out,
		input ready);
	modport sink (input valid, input motor_dir, input motor_duty, input pump_on,
		input lamp_on, input cycle_phase, input cycle_ended, input timed_out,
		output ready);
endinterface
`default_nettype wire

// File: rtl/core/wcs_cfg_regs.sv
`default_nettype none
module wcs_cfg_regs
	import wcs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [MS_W-1:0]      cfg_wdata,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	// write the addressed register, drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wash_seconds   <= SEC_W'(30);
			cfg_q.rinse_seconds  <= SEC_W'(20);
			cfg_q.spin_seconds   <= SEC_W'(10);
			cfg_q.motor_speed    <= DUTY_W'(200);
			cfg_q.debounce_ms    <= DEB_W'(1500);
			cfg_q.rest_ms        <= MS_W'(60000);
			cfg_q.run_limit_ms   <= MS_W'(600000);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_WASH_SECONDS:   cfg_q.wash_seconds   <= cfg_wdata[SEC_W-1:0];
				CFG_RINSE_SECONDS:  cfg_q.rinse_seconds  <= cfg_wdata[SEC_W-1:0];
				CFG_SPIN_SECONDS:   cfg_q.spin_seconds   <= cfg_wdata[SEC_W-1:0];
				CFG_MOTOR_SPEED:    cfg_q.motor_speed    <= cfg_wdata[DUTY_W-1:0];
				CFG_DEBOUNCE_MS:    cfg_q.debounce_ms    <= cfg_wdata[DEB_W-1:0];
				CFG_REST_MS:        cfg_q.rest_ms        <= cfg_wdata;
				CFG_RUN_LIMIT_MS:   cfg_q.run_limit_ms   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// File: rtl/core/wcs_engine.sv
`default_nettype none
module wcs_engine
	import wcs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  wire logic sensor_edge,
	input  cfg_t      cfg,
	output res_t      res,
	output phase_t    phase
);

	phase_t                phase_q;
	logic [PHASE_MS_W-1:0] phase_elapsed_q;
	logic [MS_W-1:0]       cycle_elapsed_q;
	logic [MS_W-1:0]       since_edge_q;
	logic [MS_W-1:0]       since_end_q;

	phase_t                phase_d;
	logic [PHASE_MS_W-1:0] phase_elapsed_d;
	logic [MS_W-1:0]       cycle_elapsed_d;
	logic [MS_W-1:0]       since_edge_d;
	logic [MS_W-1:0]       since_end_d;
	logic                  ended;
	logic                  tout;
	logic                  edge_ok;
	logic [SEC_W-1:0]      secs;
	logic [PHASE_MS_W-1:0] limit_ms;

	// next state for one tick
	always_comb begin
		since_edge_d    = (since_edge_q == MAX24) ? MAX24 : since_edge_q + 1'b1;
		since_end_d     = (since_end_q == MAX24) ? MAX24 : since_end_q + 1'b1;
		phase_d         = phase_q;
		phase_elapsed_d = phase_elapsed_q;
		cycle_elapsed_d = cycle_elapsed_q;
		ended           = 1'b0;
		tout            = 1'b0;
		if (phase_q != PH_IDLE) begin
			phase_elapsed_d = (phase_elapsed_q == MAX22) ? MAX22 : phase_elapsed_q + 1'b1;
			cycle_elapsed_d = (cycle_elapsed_q == MAX24) ? MAX24 : cycle_elapsed_q + 1'b1;
		end

		// debounce the edge, start a cycle once cooled down
		edge_ok = sensor_edge && (since_edge_d > {{(MS_W-DEB_W){1'b0}}, cfg.debounce_ms});
		if (edge_ok) begin
			since_edge_d = '0;
			if (phase_q == PH_IDLE && since_end_d > cfg.rest_ms) begin
				phase_d         = PH_WASH;
				phase_elapsed_d = '0;
				cycle_elapsed_d = '0;
			end
		end

		// pick the running phase length
		case (phase_d)
			PH_WASH:  secs = cfg.wash_seconds;
			PH_RINSE: secs = cfg.rinse_seconds;
			default:  secs = cfg.spin_seconds;
		endcase
		limit_ms = PHASE_MS_W'(secs) * MS_PER_S;

		// watchdog first, then phase advance
		if (phase_d != PH_IDLE) begin
			if (cycle_elapsed_d > cfg.run_limit_ms) begin
				ended = 1'b1;
				tout  = 1'b1;
			end else if (phase_elapsed_d >= limit_ms) begin
				case (phase_d)
					PH_WASH:  phase_d = PH_RINSE;
					PH_RINSE: phase_d = PH_SPIN;
					default:  ended   = 1'b1;
				endcase
				phase_elapsed_d = '0;
			end
			if (ended) begin
				phase_d         = PH_IDLE;
				phase_elapsed_d = '0;
				cycle_elapsed_d = '0;
				since_end_d     = '0;
			end
		end
	end

	// drive actuators from the phase after the tick
	always_comb begin
		res.cycle_phase = phase_d;
		res.cycle_ended = ended;
		res.timed_out   = tout;
		res.pump_on     = (phase_d != PH_IDLE);
		res.lamp_on     = (phase_d != PH_IDLE);
		case (phase_d)
			PH_WASH, PH_RINSE: begin
				res.motor_dir  = DIR_FWD;
				res.motor_duty = cfg.motor_speed;
			end
			PH_SPIN: begin
				res.motor_dir  = DIR_REV;
				res.motor_duty = cfg.motor_speed >> 1;
			end
			default: begin
				res.motor_dir  = DIR_STOP;
				res.motor_duty = '0;
			end
		endcase
	end

	// commit the tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			phase_elapsed_q <= '0;
			cycle_elapsed_q <= '0;
			since_edge_q    <= '0;
			since_end_q     <= '0;
		end else if (step) begin
			phase_q         <= phase_d;
			phase_elapsed_q <= phase_elapsed_d;
			cycle_elapsed_q <= cycle_elapsed_d;
			since_edge_q    <= since_edge_d;
			since_end_q     <= since_end_d;
		end
	end

	assign phase = phase_q;

endmodule
`default_nettype wire

// File: rtl/core/wash_cycle_sequencer.sv
// channel   dir  payload                                            beat
// sensor    in   sensor_edge                                        one 1 ms tick
// result    out  motor_dir motor_duty pump_on lamp_on cycle_phase   one per tick
//                cycle_ended timed_out
// cfg       in   cfg_we cfg_idx cfg_wdata                           one register write
//
// One tick per clock sustained while results are taken; each result passes the input
// register, then the result register after the single-pass state update.
// Reset (arst_n low) loads the register defaults and clears all counters to idle.
// A stalled result holds the result register and the input register; sensor ready
// drops only when both are full and the result is not taken.
`default_nettype none
module wash_cycle_sequencer
	import wcs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	wcs_in_if.sink                    sensor,
	wcs_out_if.source                 result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [MS_W-1:0]      cfg_wdata
);

	cfg_t   cfg;
	res_t   res;
	phase_t phase;

	logic valid_s1;
	logic edge_s1;
	logic out_valid_q;
	res_t out_q;
	logic advance;

	// move the held tick into the result register when it has room
	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign sensor.ready = !valid_s1 || advance;

	wcs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	wcs_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.sensor_edge (edge_s1),
		.cfg         (cfg),
		.res         (res),
		.phase       (phase)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sensor.ready) begin
			valid_s1 <= sensor.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sensor.valid && sensor.ready) begin
			edge_s1 <= sensor.sensor_edge;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.motor_dir   = out_q.motor_dir;
	assign result.motor_duty  = out_q.motor_duty;
	assign result.pump_on     = out_q.pump_on;
	assign result.lamp_on     = out_q.lamp_on;
	assign result.cycle_phase = out_q.cycle_phase;
	assign result.cycle_ended = out_q.cycle_ended;
	assign result.timed_out   = out_q.timed_out;

	// a cycle end leaves the engine idle
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.cycle_ended |=> phase == PH_IDLE)
		else $error("engine not idle after cycle end");

	// phase moves at most one step forward, or back to idle; a start may pass
	// straight through an empty wash into rinse
	a_phase_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (phase == $past(phase)) || (phase == PH_IDLE) ||
			(phase == phase_t'($past(phase) + 2'd1)) ||
			(($past(phase) == PH_IDLE) && (phase == PH_RINSE)))
		else $error("phase skipped");

	// no tick taken, no state change
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(phase))
		else $error("phase moved without a tick");

	// a timeout is always reported as a cycle end
	a_tout_ended: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.timed_out |=> out_valid_q && out_q.cycle_ended)
		else $error("timeout without cycle end");

endmodule
`default_nettype wire
